[hdl/pfsm_pkg.sv]
package pfsm_pkg;

  localparam int unsigned CFG_W     = 20;
  localparam int unsigned SEQ_W     = 48;
  localparam int unsigned BYTES_W   = 16;
  localparam int unsigned IDX_W     = 32;
  localparam int unsigned WSUM_W    = 22;
  localparam int unsigned THR_W     = 32;
  localparam int unsigned GAP_W     = SEQ_W + 1;
  localparam logic [CFG_W-1:0] WINDOW_US_RST = CFG_W'(50000);
  localparam int unsigned KBPS_SCALE = 8000;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input word, scalar stats
    logic drop;      // remove oldest entry
    logic append;    // write new entry
    logic expire;    // remove oldest entry (expiry)
    logic rd_head;   // issue read of head time
    logic div_start; // start divider
    logic div_step;  // one divider step
    logic emit;      // build result
  } pfsm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic expire_hit;
    logic div_done;
  } pfsm_sts_t;

endpackage

[hdl/pfsm_ctrl.sv]
module pfsm_ctrl
  import pfsm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      out_fire,
  input  pfsm_sts_t sts,
  output pfsm_cmd_t cmd,
  output logic      busy,
  output logic      out_valid
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_APPEND, S_RDH, S_EXP, S_DIVST, S_DIV, S_EMIT, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.full) cmd.drop = 1'b1;
        state_nxt = S_APPEND;
      end
      S_APPEND: begin
        cmd.append = 1'b1;
        state_nxt = S_RDH;
      end
      S_RDH: begin
        cmd.rd_head = 1'b1;
        state_nxt = S_EXP;
      end
      S_EXP: begin
        if (sts.expire_hit) begin
          cmd.expire = 1'b1;
          state_nxt = S_RDH;
        end else begin
          state_nxt = S_DIVST;
        end
      end
      S_DIVST: begin
        cmd.div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

endmodule

[hdl/pfsm_dp.sv]
module pfsm_dp
  import pfsm_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 64,
  parameter int unsigned TIME_WIDTH   = 40
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pfsm_cmd_t                cmd,
  output pfsm_sts_t                sts,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_wdata,
  input  logic [TIME_WIDTH-1:0]    i_rx_time,
  input  logic                     i_has_tx,
  input  logic [TIME_WIDTH-1:0]    i_tx_time,
  input  logic                     i_has_seq,
  input  logic [SEQ_W-1:0]         i_seq,
  input  logic                     i_has_tag,
  input  logic [BYTES_W-1:0]       i_tag,
  input  logic [BYTES_W-1:0]       i_rx_bytes,
  output logic [IDX_W-1:0]         o_idx,
  output logic [TIME_WIDTH:0]      o_iat,
  output logic [TIME_WIDTH:0]      o_lat,
  output logic [TIME_WIDTH-1:0]    o_jit,
  output logic [SEQ_W-1:0]         o_seq,
  output logic [GAP_W-1:0]         o_gap,
  output logic [BYTES_W-1:0]       o_txb,
  output logic [WSUM_W-1:0]        o_wbytes,
  output logic [THR_W-1:0]         o_thr,
  output logic                     o_ovf
);

  localparam int unsigned AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W = BYTES_W + CW;
  localparam int unsigned NUM_W = SUM_W + 13;  // times 8000
  localparam int unsigned DEN_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;
  localparam int unsigned DCW   = $clog2(NUM_W + 1);

  logic [TIME_WIDTH-1:0] mem_t [WINDOW_DEPTH];
  logic [BYTES_W-1:0]    mem_b [WINDOW_DEPTH];

  logic [CFG_W-1:0]      win_r;
  logic                  have_rx_r, have_gap_r, have_seq_r;
  logic [TIME_WIDTH-1:0] last_rx_r, last_gap_r;
  logic [SEQ_W-1:0]      last_seq_r;
  logic [IDX_W-1:0]      cnt_r;
  logic [AW-1:0]         head_r;
  logic [CW-1:0]         count_r;
  logic [SUM_W-1:0]      sum_r;
  logic [TIME_WIDTH-1:0] now_r;
  logic [BYTES_W-1:0]    rxb_r;
  logic [TIME_WIDTH-1:0] head_t_r;
  logic [BYTES_W-1:0]    head_b_r;
  logic                  ovf_r;

  logic [NUM_W-1:0]      q_r, rem_n_r;
  logic [DEN_W:0]        rem_r;
  logic [DEN_W-1:0]      den_r;
  logic [DCW-1:0]        dcnt_r;

  // ring index arithmetic
  logic [AW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic [AW-1:0] head_inc;
  assign tail_sum = {1'b0, head_r} + (AW+1)'(count_r);
  assign tail = (tail_sum >= (AW+1)'(WINDOW_DEPTH)) ?
                AW'(tail_sum - (AW+1)'(WINDOW_DEPTH)) : AW'(tail_sum);
  assign head_inc = (head_r == AW'(WINDOW_DEPTH - 1)) ? '0 : head_r + 1'b1;

  // expiry test on registered head time
  logic [TIME_WIDTH-1:0] cutoff;
  logic                  exp_en;
  assign exp_en = (now_r >= TIME_WIDTH'(win_r));
  assign cutoff = now_r - TIME_WIDTH'(win_r);

  assign sts.full       = (count_r >= CW'(WINDOW_DEPTH));
  assign sts.empty      = (count_r == '0);
  assign sts.expire_hit = exp_en && (count_r != '0) && (head_t_r < cutoff);
  assign sts.div_done   = (dcnt_r == '0);

  // head size is read at accept (for a full-ring drop) and with each head time read
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem_t[tail] <= now_r;
      mem_b[tail] <= rxb_r;
    end
    if (cmd.rd_head) head_t_r <= mem_t[head_r];
    if (cmd.load || cmd.rd_head) head_b_r <= mem_b[head_r];
  end

  // denominator choice
  logic [TIME_WIDTH-1:0] span;
  logic [DEN_W-1:0]      den_sel;
  always_comb begin
    span = (now_r >= head_t_r) ? now_r - head_t_r : '0;
    den_sel = DEN_W'(win_r);
    if (count_r != '0 && span != '0 && span < TIME_WIDTH'(win_r))
      den_sel = DEN_W'(span);
  end

  // restoring divider step
  logic [DEN_W:0] rem_sh;
  assign rem_sh = {rem_r[DEN_W-1:0], rem_n_r[NUM_W-1]};

  // scalar stats
  logic [TIME_WIDTH-1:0] iat;
  logic [TIME_WIDTH-1:0] jit;
  logic [TIME_WIDTH-1:0] lat;
  assign iat = (i_rx_time >= last_rx_r) ? i_rx_time - last_rx_r : '0;
  assign jit = (have_rx_r && have_gap_r) ?
               ((iat >= last_gap_r) ? iat - last_gap_r : last_gap_r - iat) : '0;
  assign lat = (i_rx_time >= i_tx_time) ? i_rx_time - i_tx_time : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= WINDOW_US_RST;
      have_rx_r  <= 1'b0;
      have_gap_r <= 1'b0;
      have_seq_r <= 1'b0;
      last_rx_r  <= '0;
      last_gap_r <= '0;
      last_seq_r <= '0;
      cnt_r      <= '0;
      head_r     <= '0;
      count_r    <= '0;
      sum_r      <= '0;
      dcnt_r     <= '0;
    end else begin
      if (cfg_we) win_r <= cfg_wdata;
      if (cmd.load) begin
        now_r <= i_rx_time;
        rxb_r <= i_rx_bytes;
        ovf_r <= 1'b0;
        o_idx <= cnt_r;
        o_txb <= i_has_tag ? i_tag : i_rx_bytes;
        o_jit <= jit;
        if (have_rx_r) begin
          o_iat <= {1'b0, iat};
          last_gap_r <= iat;
          have_gap_r <= 1'b1;
        end else begin
          o_iat <= '1;
        end
        last_rx_r <= i_rx_time;
        have_rx_r <= 1'b1;
        if (i_has_tx)
          o_lat <= {1'b0, lat};
        else
          o_lat <= '1;
        if (i_has_seq) begin
          o_seq <= i_seq;
          o_gap <= (have_seq_r && i_seq > last_seq_r) ?
                   {1'b0, i_seq - last_seq_r - 1'b1} : '0;
          last_seq_r <= i_seq;
          have_seq_r <= 1'b1;
        end else begin
          o_seq <= '0;
          o_gap <= '1;
        end
      end
      if (cmd.drop || cmd.expire) begin
        sum_r   <= sum_r - SUM_W'(head_b_r);
        head_r  <= head_inc;
        count_r <= count_r - 1'b1;
      end
      if (cmd.drop) ovf_r <= 1'b1;
      if (cmd.append) begin
        sum_r   <= sum_r + SUM_W'(rxb_r);
        count_r <= count_r + 1'b1;
      end
      if (cmd.div_start) begin
        rem_n_r <= NUM_W'(sum_r) * NUM_W'(KBPS_SCALE);
        den_r   <= den_sel;
        rem_r   <= '0;
        q_r     <= '0;
        dcnt_r  <= DCW'(NUM_W);
      end
      if (cmd.div_step) begin
        rem_n_r <= rem_n_r << 1;
        dcnt_r  <= dcnt_r - 1'b1;
        if (rem_sh >= {1'b0, den_r}) begin
          rem_r <= rem_sh - {1'b0, den_r};
          q_r   <= {q_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          q_r   <= {q_r[NUM_W-2:0], 1'b0};
        end
      end
      cnt_r <= cmd.emit ? cnt_r + 1'b1 : cnt_r;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_ovf    <= ovf_r;
      o_wbytes <= (sum_r > SUM_W'({WSUM_W{1'b1}})) ? '1 : WSUM_W'(sum_r);
      if (den_r == '0)
        o_thr <= '0;
      else if (q_r > NUM_W'({THR_W{1'b1}}))
        o_thr <= '1;
      else
        o_thr <= THR_W'(q_r);
    end
  end

endmodule

[hdl/packet_flow_stats_monitor_core.sv]
// sequence: input accept, full check, append, head read and expiry test (repeated
//   per expired window entry), divider start, 36 serial divider steps, result, output
// throughput: one packet at a time; input is blocked while a packet is in flight,
//   including entry expiry passes and a stalled output word
// reset: rst_n synchronous active low; clears counters, history and window ring
//   pointers, window_us returns to 50000
module packet_flow_stats_monitor_core
  import pfsm_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 64,
  parameter int unsigned TIME_WIDTH   = 40
) (
  input  logic clk,
  input  logic rst_n,
  // rx_time_us, has_tx_stamp, tx_time_us, has_seq, seq_num, has_size_tag,
  // tagged_size, rx_bytes, pad
  input  logic [((2*TIME_WIDTH+SEQ_W+2*BYTES_W+3+7)/8)*8-1:0] in_tdata,
  input  logic in_tvalid,
  output logic in_tready,
  // pkt_index, inter-arrival time, one-way delay, arrival variation, seq_out,
  // seq_gap, send size, window_bytes, throughput_kbps, window_overflow, pad
  output logic [((IDX_W+3*TIME_WIDTH+2+SEQ_W+GAP_W+BYTES_W+WSUM_W+THR_W+1+7)/8)*8-1:0]
               out_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  input  logic cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // input layout offsets, lowest first
  localparam int unsigned O_HTX = TIME_WIDTH;
  localparam int unsigned O_TX  = O_HTX + 1;
  localparam int unsigned O_HSQ = O_TX + TIME_WIDTH;
  localparam int unsigned O_SQ  = O_HSQ + 1;
  localparam int unsigned O_HTG = O_SQ + SEQ_W;
  localparam int unsigned O_TG  = O_HTG + 1;
  localparam int unsigned O_RB  = O_TG + BYTES_W;
  localparam int unsigned OUT_N = IDX_W + 3*TIME_WIDTH + 2 + SEQ_W + GAP_W + BYTES_W
                                  + WSUM_W + THR_W + 1;
  localparam int unsigned OUT_W = ((OUT_N + 7) / 8) * 8;

  pfsm_cmd_t cmd;
  pfsm_sts_t sts;
  logic      busy;

  logic [IDX_W-1:0]      o_idx;
  logic [TIME_WIDTH:0]   o_iat, o_lat;
  logic [TIME_WIDTH-1:0] o_jit;
  logic [SEQ_W-1:0]      o_seq;
  logic [GAP_W-1:0]      o_gap;
  logic [BYTES_W-1:0]    o_txb;
  logic [WSUM_W-1:0]     o_wbytes;
  logic [THR_W-1:0]      o_thr;
  logic                  o_ovf;

  assign in_tready = !busy;

  pfsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_tvalid && in_tready),
    .out_fire  (out_tvalid && out_tready),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_tvalid)
  );

  pfsm_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .TIME_WIDTH   (TIME_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .i_rx_time  (in_tdata[TIME_WIDTH-1:0]),
    .i_has_tx   (in_tdata[O_HTX]),
    .i_tx_time  (in_tdata[O_TX +: TIME_WIDTH]),
    .i_has_seq  (in_tdata[O_HSQ]),
    .i_seq      (in_tdata[O_SQ +: SEQ_W]),
    .i_has_tag  (in_tdata[O_HTG]),
    .i_tag      (in_tdata[O_TG +: BYTES_W]),
    .i_rx_bytes (in_tdata[O_RB +: BYTES_W]),
    .o_idx      (o_idx),
    .o_iat      (o_iat),
    .o_lat      (o_lat),
    .o_jit      (o_jit),
    .o_seq      (o_seq),
    .o_gap      (o_gap),
    .o_txb      (o_txb),
    .o_wbytes   (o_wbytes),
    .o_thr      (o_thr),
    .o_ovf      (o_ovf)
  );

  assign out_tdata = OUT_W'({o_ovf, o_thr, o_wbytes, o_txb, o_gap, o_seq, o_jit,
                             o_lat, o_iat, o_idx});

endmodule

[hdl/pfsm_checker.sv]
module pfsm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready
);

  // one packet in flight: no input taken while a result waits
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");

  // a result never appears right after accept
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !out_tvalid) else $error("result too early");

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");

  // after a result is taken the block is ready again
  a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> in_tready) else $error("not ready after result");

endmodule

bind packet_flow_stats_monitor_core pfsm_checker u_pfsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

[test/packet_flow_stats_monitor_core_test.sv]
module packet_flow_stats_monitor_core_test;
  import pfsm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // port widths, same formulas as the block's port list
  localparam int unsigned TW    = 40;
  localparam int unsigned DEPTH = 64;
  localparam int unsigned IN_W  = ((2*TW+SEQ_W+2*BYTES_W+3+7)/8)*8;
  localparam int unsigned OUT_W =
    ((IDX_W+3*TW+2+SEQ_W+GAP_W+BYTES_W+WSUM_W+THR_W+1+7)/8)*8;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam longint unsigned TMAX = (64'd1 << TW) - 1;

  // one received packet
  typedef struct {
    bit [TW-1:0]      rx_time;
    bit               has_tx;
    bit [TW-1:0]      tx_time;
    bit               has_seq;
    bit [SEQ_W-1:0]   seq;
    bit               has_tag;
    bit [BYTES_W-1:0] tag;
    bit [BYTES_W-1:0] rx_bytes;
  } pkt_t;

  // one statistics word
  typedef struct {
    bit [IDX_W-1:0]   idx;
    bit [TW:0]        iat;
    bit [TW:0]        lat;
    bit [TW-1:0]      jit;
    bit [SEQ_W-1:0]   seq;
    bit [GAP_W-1:0]   gap;
    bit [BYTES_W-1:0] txb;
    bit [WSUM_W-1:0]  wb;
    bit [THR_W-1:0]   thr;
    bit               ovf;
  } stats_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  packet_flow_stats_monitor_core #(
    .WINDOW_DEPTH(DEPTH),
    .TIME_WIDTH  (TW)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  pkt_t   pkt_q[$];      // packets waiting to be sent
  stats_t stats_q[$];    // statistics words still owed by the block
  pkt_t   cur_pkt;       // packet currently on the input bus
  int     mismatches = 0;

  // mirror of the block's state
  longint unsigned win_us = 50000;
  bit              seen_rx, seen_gap, seen_seq;
  longint unsigned prev_rx, prev_gap, prev_seq;
  bit [IDX_W-1:0]  pkt_count;
  longint unsigned ring_time [DEPTH];
  longint unsigned ring_size [DEPTH];
  int unsigned     ring_head, ring_cnt;
  longint unsigned ring_sum;

  function automatic logic [IN_W-1:0] pack_pkt(pkt_t p);
    return IN_W'({p.rx_bytes, p.tag, p.has_tag, p.seq, p.has_seq,
                  p.tx_time, p.has_tx, p.rx_time});
  endfunction

  function automatic stats_t unpack_stats(logic [OUT_W-1:0] d);
    stats_t s;
    s.idx = d[31:0];
    s.iat = d[72:32];
    s.lat = d[113:73];
    s.jit = d[153:114];
    s.seq = d[201:154];
    s.gap = d[250:202];
    s.txb = d[266:251];
    s.wb  = d[288:267];
    s.thr = d[320:289];
    s.ovf = d[321];
    return s;
  endfunction

  function automatic void ring_pop();
    ring_sum  -= ring_size[ring_head];
    ring_head  = (ring_head + 1) % DEPTH;
    ring_cnt--;
  endfunction

  // statistics of one packet; advances the mirrored state
  function automatic stats_t flow_stats(pkt_t p);
    stats_t          s;
    longint unsigned now, iat, span, denom, thr, first;
    now = p.rx_time;
    s.jit = '0;
    // inter-arrival and jitter
    if (seen_rx) begin
      iat = (now >= prev_rx) ? now - prev_rx : 0;
      s.iat = (TW+1)'(iat);
      if (seen_gap)
        s.jit = TW'((iat >= prev_gap) ? iat - prev_gap : prev_gap - iat);
      prev_gap = iat;
      seen_gap = 1'b1;
    end else begin
      s.iat = '1;
    end
    prev_rx = now;
    seen_rx = 1'b1;
    // one-way latency, clamped at zero
    if (p.has_tx) s.lat = (now >= p.tx_time) ? (TW+1)'(now - p.tx_time) : '0;
    else s.lat = '1;
    // sequence gap
    if (p.has_seq) begin
      s.seq = p.seq;
      s.gap = (seen_seq && p.seq > prev_seq) ? GAP_W'(p.seq - prev_seq - 1) : '0;
      prev_seq = p.seq;
      seen_seq = 1'b1;
    end else begin
      s.seq = '0;
      s.gap = '1;
    end
    // window ring: drop oldest when full, append, then expire
    s.ovf = 1'b0;
    if (ring_cnt >= DEPTH) begin
      ring_pop();
      s.ovf = 1'b1;
    end
    ring_time[(ring_head + ring_cnt) % DEPTH] = now;
    ring_size[(ring_head + ring_cnt) % DEPTH] = p.rx_bytes;
    ring_cnt++;
    ring_sum += p.rx_bytes;
    if (now >= win_us)
      while (ring_cnt > 0 && ring_time[ring_head] < now - win_us) ring_pop();
    // throughput over the effective span
    denom = win_us;
    if (ring_cnt > 0) begin
      first = ring_time[ring_head];
      span = (now >= first) ? now - first : 0;
      if (span >= 1 && span < win_us) denom = span;
    end
    thr = 0;
    if (denom > 0) begin
      thr = ring_sum * KBPS_SCALE / denom;
      if (thr > 64'hFFFF_FFFF) thr = 64'hFFFF_FFFF;
    end
    s.thr = THR_W'(thr);
    s.wb  = (ring_sum > 64'h3F_FFFF) ? 22'h3F_FFFF : WSUM_W'(ring_sum);
    s.txb = p.has_tag ? p.tag : p.rx_bytes;
    s.idx = pkt_count;
    pkt_count++;
    return s;
  endfunction

  // sender: bursts of random length with random gaps
  int unsigned burst_left = 1, gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        stats_q.push_back(flow_stats(cur_pkt));
        pkt_q.delete(0);
      end
      if (in_tvalid && !in_tready) begin
        // hold the word until taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pkt_q.size() > 0) begin
        cur_pkt = pkt_q[0];
        in_tdata  <= pack_pkt(pkt_q[0]);
        in_tvalid <= 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  task automatic report(string name, longint unsigned e, longint unsigned a);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected 0x%0h actual 0x%0h", name, e, a);
  endtask

  // receiver: checks each taken word; stall pattern picked at random from three
  int unsigned rx_cyc = 0, stall_mode = 0;
  always @(posedge clk) begin
    stats_t act, exp_s;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        act = unpack_stats(out_tdata);
        if (stats_q.size() == 0) begin
          report("unexpected word idx", 0, act.idx);
        end else begin
          exp_s = stats_q[0];
          stats_q.delete(0);
          if (act.idx != exp_s.idx) report("pkt_index", exp_s.idx, act.idx);
          if (act.iat != exp_s.iat) report("inter-arrival", exp_s.iat, act.iat);
          if (act.lat != exp_s.lat) report("one-way delay", exp_s.lat, act.lat);
          if (act.jit != exp_s.jit) report("arrival variation", exp_s.jit, act.jit);
          if (act.seq != exp_s.seq) report("seq_out", exp_s.seq, act.seq);
          if (act.gap != exp_s.gap) report("seq_gap", exp_s.gap, act.gap);
          if (act.txb != exp_s.txb) report("send size", exp_s.txb, act.txb);
          if (act.wb  != exp_s.wb)  report("window_bytes", exp_s.wb, act.wb);
          if (act.thr != exp_s.thr) report("throughput_kbps", exp_s.thr, act.thr);
          if (act.ovf != exp_s.ovf) report("window_overflow", exp_s.ovf, act.ovf);
        end
      end
      if (rx_cyc % 64 == 0) stall_mode = $urandom_range(0, 2);
      rx_cyc++;
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // watchdog: cycles with no accepted word on either side
  int unsigned quiet = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // packet generator
  longint unsigned gen_time = 0;
  longint unsigned gen_seq = 0;

  task automatic add_pkt(bit well_formed);
    pkt_t p;
    int   r;
    r = $urandom_range(0, 99);
    if (!well_formed && r < 30)
      gen_time = {$urandom, $urandom} & TMAX;          // jump anywhere, maybe back
    else if (r < 10) gen_time = gen_time;              // same time
    else if (r < 75) gen_time += $urandom_range(1, 600);
    else if (r < 95) gen_time += $urandom_range(1, 60000);
    else gen_time += $urandom_range(1, 1 << 21);
    gen_time &= TMAX;
    p.rx_time  = TW'(gen_time);
    p.has_tx   = $urandom_range(0, 3) != 0;
    p.tx_time  = (!well_formed || $urandom_range(0, 9) == 0) ?
                 TW'({$urandom, $urandom} & TMAX) :
                 TW'((gen_time - $urandom_range(0, 5000)) & TMAX);
    p.has_seq  = $urandom_range(0, 4) != 0;
    if (!well_formed || $urandom_range(0, 19) == 0) gen_seq = {$urandom, $urandom};
    else gen_seq += $urandom_range(0, 4);
    p.seq      = SEQ_W'(gen_seq);
    p.has_tag  = 1'($urandom_range(0, 1));
    p.tag      = BYTES_W'($urandom);
    p.rx_bytes = ($urandom_range(0, 3) == 0) ? BYTES_W'($urandom) :
                 BYTES_W'($urandom_range(0, 1500));
    pkt_q.push_back(p);
  endtask

  task automatic add_fixed(longint unsigned rx, bit htx, longint unsigned tx, bit hseq,
                           longint unsigned sq, bit htag, int unsigned tg, int unsigned rb);
    pkt_t p;
    p.rx_time = TW'(rx); p.has_tx = htx; p.tx_time = TW'(tx); p.has_seq = hseq;
    p.seq = SEQ_W'(sq); p.has_tag = htag; p.tag = BYTES_W'(tg); p.rx_bytes = BYTES_W'(rb);
    pkt_q.push_back(p);
    gen_time = rx;
  endtask

  task automatic wait_idle();
    while (pkt_q.size() > 0 || in_tvalid || stats_q.size() > 0) @(posedge clk);
    // idle margin after the last word is taken
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(longint unsigned v);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    win_us = v & 20'hF_FFFF;
  endtask

  longint unsigned win_set [6] = '{50000, 1, 0, 20'hF_FFFF, 1000000, 300};

  initial begin
    seen_rx = 0; seen_gap = 0; seen_seq = 0;
    prev_rx = 0; prev_gap = 0; prev_seq = 0;
    pkt_count = 0; ring_head = 0; ring_cnt = 0; ring_sum = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first packet, extremes, negative latency, seq going back
    add_fixed(0, 0, 0, 0, 0, 0, 0, 0);
    add_fixed(0, 1, 0, 1, 0, 1, 65535, 65535);
    add_fixed(10, 1, 500, 1, 5, 0, 0, 65535);            // tx later than rx
    add_fixed(25, 1, 20, 1, 5, 1, 1, 100);               // same seq
    add_fixed(25, 0, 0, 1, 2, 0, 0, 1);                  // seq going back
    add_fixed(60000, 1, 0, 1, 48'hFFFF_FFFF_FFFE, 0, 0, 40000);
    add_fixed(60001, 1, 60001, 1, 48'hFFFF_FFFF_FFFF, 1, 0, 65535);
    add_fixed(TMAX, 1, TMAX, 1, 0, 1, 12345, 65535);      // time at maximum
    add_fixed(TMAX, 1, 0, 0, 0, 0, 0, 0);                 // largest latency
    add_fixed(1000, 1, TMAX, 1, 7, 0, 0, 9);              // rx time going back
    add_fixed(1000, 0, 0, 1, 9, 0, 0, 300);
    for (int i = 0; i < 70; i++)                         // fill the ring past full
      add_fixed(1001 + i, 0, 0, 0, 0, 0, 0, 65535);
    wait_idle();

    // random phases over several window lengths
    foreach (win_set[k]) begin
      set_window(win_set[k]);
      repeat (72) add_pkt($urandom_range(0, 9) != 0);
      wait_idle();
    end
    set_window($urandom_range(1, 1000000));
    repeat (40) add_pkt(1'b1);
    wait_idle();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
hdl/pfsm_pkg.sv
hdl/pfsm_ctrl.sv
hdl/pfsm_dp.sv
hdl/packet_flow_stats_monitor_core.sv
hdl/pfsm_checker.sv
test/packet_flow_stats_monitor_core_test.sv
